// ===== rtl/length_prefix_deframer_defines.svh =====
// Assertion helpers used by the deframer RTL.
`ifndef LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== rtl/lpd_pkg.sv =====
package lpd_pkg;

    localparam int unsigned LENGTH_BYTES = 4;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_MAGIC   = 2'd0;
    localparam t_cfg_index CFG_TIMEOUT = 2'd1;

    localparam logic [7:0]  MAGIC_RESET   = 8'd93;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

    typedef logic [1:0] t_event;

    localparam t_event EV_BYTE    = 2'd0;
    localparam t_event EV_EMPTY   = 2'd1;
    localparam t_event EV_BADHDR  = 2'd2;
    localparam t_event EV_TIMEOUT = 2'd3;

    typedef logic [1:0] t_phase;

    localparam t_phase PH_HUNT    = 2'd0;
    localparam t_phase PH_LEN     = 2'd1;
    localparam t_phase PH_PAYLOAD = 2'd2;

    localparam logic        KIND_BYTE = 1'b0;
    localparam logic        KIND_TICK = 1'b1;

endpackage

// ===== rtl/lpd_in_if.sv =====
interface lpd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink (input valid, input kind, input byte_value, output ready);
endinterface

// ===== rtl/lpd_out_if.sv =====
interface lpd_out_if;
    import lpd_pkg::*;

    logic        valid;
    logic        ready;
    t_event      event_res;
    logic [7:0]  payload_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [31:0] frame_length;

    modport source (
        output valid, output event_res, output payload_byte,
        output first_of_frame, output last_of_frame, output frame_length,
        input ready
    );
    modport sink (
        input valid, input event_res, input payload_byte,
        input first_of_frame, input last_of_frame, input frame_length,
        output ready
    );
endinterface

// ===== rtl/lpd_cfg_if.sv =====
interface lpd_cfg_if;
    import lpd_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cfg_index            index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/length_prefix_deframer.sv =====
// Each result is registered: it appears on o_event in the cycle after the transfer that causes it.
// Throughput: one input item per cycle; the input stalls only while a held result
// is not taken, and the result register refills in the cycle it is emptied.
// Reset (i_rst_n low at a clock edge) returns to hunting for the magic byte, drops
// any held result and restores magic 93 and a timeout of 1000000 ticks.
`include "length_prefix_deframer_defines.svh"

module length_prefix_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpd_in_if.sink     i_byte,
    lpd_cfg_if.sink    i_cfg,
    lpd_out_if.source  o_event
);
    import lpd_pkg::*;

    localparam logic [31:0] IDLE_MAX = '1;

    // Configuration registers.
    logic [7:0]  r_magic;
    logic [31:0] r_timeout;

    // Frame state.
    t_phase      r_phase,   n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_len_acc, n_len_acc;
    logic [31:0] r_remain,  n_remain;
    logic [31:0] r_idle,    n_idle;

    // Result register.
    logic        r_valid;
    t_event      r_ev,    n_ev;
    logic [7:0]  r_pbyte, n_pbyte;
    logic        r_first, n_first;
    logic        r_last,  n_last;
    logic [31:0] r_flen,  n_flen;
    logic        n_emit;

    logic        in_xfer;
    logic [31:0] limit;
    logic [31:0] idle_inc;
    logic [31:0] len_shift;
    logic [2:0]  hdr_inc;

    assign i_byte.ready = !r_valid || o_event.ready;
    assign in_xfer      = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = 1'b1;

    assign limit     = (r_timeout == '0) ? 32'd1 : r_timeout;
    assign idle_inc  = (r_idle == IDLE_MAX) ? r_idle : r_idle + 32'd1;
    assign len_shift = {r_len_acc[23:0], i_byte.byte_value};
    assign hdr_inc   = r_hdr_cnt + 3'd1;

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_len_acc = r_len_acc;
        n_remain  = r_remain;
        n_idle    = r_idle;
        n_emit    = 1'b0;
        n_ev      = EV_BYTE;
        n_pbyte   = '0;
        n_first   = 1'b0;
        n_last    = 1'b0;
        n_flen    = '0;

        if (i_byte.kind == KIND_TICK) begin
            if (r_phase != PH_HUNT) begin
                if (idle_inc >= limit) begin
                    n_phase   = PH_HUNT;
                    n_hdr_cnt = '0;
                    n_len_acc = '0;
                    n_remain  = '0;
                    n_idle    = '0;
                    n_emit    = 1'b1;
                    n_ev      = EV_TIMEOUT;
                end else begin
                    n_idle = idle_inc;
                end
            end
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte.byte_value == r_magic) begin
                        n_phase   = PH_LEN;
                        n_hdr_cnt = '0;
                        n_len_acc = '0;
                        n_remain  = '0;
                        n_idle    = '0;
                    end else begin
                        n_emit = 1'b1;
                        n_ev   = EV_BADHDR;
                    end
                end
                PH_LEN: begin
                    n_idle    = '0;
                    n_len_acc = len_shift;
                    n_hdr_cnt = hdr_inc;
                    if (hdr_inc >= 3'(LENGTH_BYTES)) begin
                        n_hdr_cnt = '0;
                        if (len_shift == '0) begin
                            n_phase   = PH_HUNT;
                            n_len_acc = '0;
                            n_remain  = '0;
                            n_emit    = 1'b1;
                            n_ev      = EV_EMPTY;
                            n_last    = 1'b1;
                        end else begin
                            n_phase  = PH_PAYLOAD;
                            n_remain = len_shift;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_idle  = '0;
                    n_emit  = 1'b1;
                    n_ev    = EV_BYTE;
                    n_pbyte = i_byte.byte_value;
                    n_first = (r_remain == r_len_acc);
                    n_last  = (r_remain <= 32'd1);
                    n_flen  = r_len_acc;
                    if (r_remain <= 32'd1) begin
                        n_phase   = PH_HUNT;
                        n_hdr_cnt = '0;
                        n_len_acc = '0;
                        n_remain  = '0;
                    end else begin
                        n_remain = r_remain - 32'd1;
                    end
                end
                default: begin
                    // Unused phase code: fall back to hunting.
                    n_phase   = PH_HUNT;
                    n_hdr_cnt = '0;
                    n_len_acc = '0;
                    n_remain  = '0;
                    n_idle    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_MAGIC:   r_magic   <= i_cfg.data[7:0];
                CFG_TIMEOUT: r_timeout <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr_cnt <= '0;
            r_len_acc <= '0;
            r_remain  <= '0;
            r_idle    <= '0;
        end else if (in_xfer) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_len_acc <= n_len_acc;
            r_remain  <= n_remain;
            r_idle    <= n_idle;
        end
    end

    // The result register is reloaded in the same cycle its previous content transfers out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer && n_emit) begin
            r_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_ev    <= n_ev;
            r_pbyte <= n_pbyte;
            r_first <= n_first;
            r_last  <= n_last;
            r_flen  <= n_flen;
        end
    end

    assign o_event.valid          = r_valid;
    assign o_event.event_res      = r_ev;
    assign o_event.payload_byte   = r_pbyte;
    assign o_event.first_of_frame = r_first;
    assign o_event.last_of_frame  = r_last;
    assign o_event.frame_length   = r_flen;

    `LPD_ASSERT_NOW(a_err_no_payload, i_clk, i_rst_n,
        r_valid && (r_ev == EV_BADHDR || r_ev == EV_TIMEOUT),
        r_pbyte == '0 && !r_first && !r_last && r_flen == '0)
    `LPD_ASSERT_NOW(a_hunt_clean, i_clk, i_rst_n,
        r_phase == PH_HUNT,
        r_idle == '0 && r_remain == '0 && r_hdr_cnt == '0)
    `LPD_ASSERT_NOW(a_hdr_cnt_range, i_clk, i_rst_n,
        1'b1, r_hdr_cnt < 3'(LENGTH_BYTES))
    `LPD_ASSERT_NEXT(a_payload_count, i_clk, i_rst_n,
        in_xfer && i_byte.kind == KIND_BYTE && r_phase == PH_PAYLOAD && r_remain > 32'd1,
        r_remain == $past(r_remain) - 32'd1 && r_phase == PH_PAYLOAD)

endmodule
